/* sv/continued_fraction_rationalizer_macros.svh */
// Assertion macros for the continued fraction rationalizer.
// Expects clk and arst_n in the scope of each use.
`ifndef CONTINUED_FRACTION_RATIONALIZER_MACROS_SVH
`define CONTINUED_FRACTION_RATIONALIZER_MACROS_SVH

// same-cycle implication
`define CFR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cfr: assertion failed");

// next-cycle implication
`define CFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cfr: assertion failed");

`endif

/* sv/cfr_pkg.sv */
// Package for the continued fraction rationalizer: widths, limits, item types.
// No dependencies.
`default_nettype none
package cfr_pkg;

	localparam int MAG_W  = 63;
	localparam int NUM_W  = 31;
	localparam int PROD_W = 2 * NUM_W;

	localparam int FRAC_BITS_DEF = 32;
	localparam int MAX_TERMS_DEF = 100;

	localparam logic [NUM_W-1:0] NUM_LIMIT = {NUM_W{1'b1}};

	typedef struct packed {
		logic             negative;
		logic [MAG_W-1:0] magnitude;
	} value_t;

	typedef struct packed {
		logic             result_negative;
		logic [NUM_W-1:0] numerator;
		logic [NUM_W-1:0] denominator;
	} ratio_t;

endpackage
`default_nettype wire

/* sv/cfr_stream_if.sv */
// Valid/ready stream interface carrying one payload item per handshake.
// Payload type is a parameter; item types come from cfr_pkg.
`default_nettype none
interface cfr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/cfr_divider.sv */
// Iterative restoring divider, one quotient bit per cycle over MAG_W bits.
// Depends on cfr_pkg and the assertion macro header.
`default_nettype none
`include "continued_fraction_rationalizer_macros.svh"
module cfr_divider
	import cfr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [MAG_W-1:0] dividend,
	input  wire logic [MAG_W-1:0] divisor,
	output logic      [MAG_W-1:0] quotient,
	output logic      [MAG_W-1:0] remainder,
	output logic                  done
);

	localparam int CNT_W = $clog2(MAG_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(MAG_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [MAG_W-1:0] den_q;

	logic [MAG_W:0] trial;
	logic [MAG_W:0] diff;
	logic           take;

	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign take  = !diff[MAG_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], take};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

	`CFR_ASSERT_NOW(a_done_idle, done_q, !busy_q)
	`CFR_ASSERT_NEXT(a_start_busy, start, busy_q && !done_q)
	`CFR_ASSERT_NEXT(a_busy_ends_done, busy_q && !start, busy_q || done_q)

endmodule
`default_nettype wire

/* sv/cfr_mac.sv */
// Shared multiply-add with 31-bit limit check for convergent updates.
// Value and fits appear in the cycle after the operands; depends on cfr_pkg.
`default_nettype none
module cfr_mac
	import cfr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic [MAG_W-1:0] term,
	input  wire logic [NUM_W-1:0] x1,
	input  wire logic [NUM_W-1:0] x0,
	output logic      [NUM_W-1:0] value,
	output logic                  fits
);

	logic [PROD_W-1:0] prod_s1;
	logic [NUM_W-1:0]  x0_s1;
	logic              ovf_s1;
	logic [PROD_W:0]   sum;

	// a term of 2^31 or more overflows whenever x1 is nonzero
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(term[NUM_W-1:0]) * PROD_W'(x1);
		x0_s1   <= x0;
		ovf_s1  <= (|term[MAG_W-1:NUM_W]) && (|x1);
	end

	assign sum   = {1'b0, prod_s1} + (PROD_W + 1)'(x0_s1);
	assign fits  = !ovf_s1 && (sum <= (PROD_W + 1)'(NUM_LIMIT));
	assign value = sum[NUM_W-1:0];

endmodule
`default_nettype wire

/* sv/continued_fraction_rationalizer.sv */
// Continued fraction rationalizer: value stream in, convergent stream out.
// Depends on cfr_pkg, cfr_stream_if, cfr_divider, cfr_mac, macro header.
//
// Usage:
//   value_ch carries a sign and a fixed-point magnitude with FRAC_BITS
//   fraction bits; ratio_ch returns the sign and the last convergent
//   numerator/denominator that fit in 31 bits (1/0 when none fit).
//   One item is in flight at a time: value_ch.ready is high only when idle.
//   Each continued-fraction term runs the bit-serial divider (one quotient
//   bit per cycle over 63 bits), then the shared multiplier for the
//   numerator and then the denominator, then a check state; at most
//   MAX_TERMS terms are computed for one item.
//   The result is held on ratio_ch until taken; a stalled receiver keeps
//   the block from accepting the next item.
//   Reset clears the sequencer and the divider control; an item in flight
//   is dropped and none is produced across reset; no clearing pass is needed.
`default_nettype none
`include "continued_fraction_rationalizer_macros.svh"
module continued_fraction_rationalizer
	import cfr_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cfr_stream_if.sink   value_ch,
	cfr_stream_if.source ratio_ch
);

	localparam int CNT_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam logic [CNT_W-1:0] LAST_TERM = CNT_W'(MAX_TERMS - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_MULH  = 3'd2;
	localparam logic [2:0] S_MULK  = 3'd3;
	localparam logic [2:0] S_CHECK = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             div_start_q;
	logic             neg_q;
	logic             hfit_q;
	logic [MAG_W-1:0] p_q;
	logic [MAG_W-1:0] q_q;
	logic [NUM_W-1:0] h0_q;
	logic [NUM_W-1:0] h1_q;
	logic [NUM_W-1:0] k0_q;
	logic [NUM_W-1:0] k1_q;
	logic [NUM_W-1:0] h2_q;

	logic [MAG_W-1:0] div_quo;
	logic [MAG_W-1:0] div_rem;
	logic             div_done;
	logic [NUM_W-1:0] mac_x1;
	logic [NUM_W-1:0] mac_x0;
	logic [NUM_W-1:0] mac_value;
	logic             mac_fits;
	logic             accept;

	assign accept = value_ch.valid && value_ch.ready;

	cfr_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (p_q),
		.divisor   (q_q),
		.quotient  (div_quo),
		.remainder (div_rem),
		.done      (div_done)
	);

	assign mac_x1 = (state_q == S_MULK) ? k1_q : h1_q;
	assign mac_x0 = (state_q == S_MULK) ? k0_q : h0_q;

	cfr_mac u_mac (
		.clk   (clk),
		.term  (div_quo),
		.x1    (mac_x1),
		.x0    (mac_x0),
		.value (mac_value),
		.fits  (mac_fits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q     <= S_DIV;
						cnt_q       <= '0;
						div_start_q <= 1'b1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_MULH;
					end
				end
				S_MULH: begin
					state_q <= S_MULK;
				end
				S_MULK: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!(hfit_q && mac_fits) || div_rem == '0 || cnt_q == LAST_TERM) begin
						state_q <= S_OUT;
					end else begin
						state_q     <= S_DIV;
						cnt_q       <= cnt_q + 1'b1;
						div_start_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (ratio_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			neg_q <= value_ch.data.negative;
			p_q   <= value_ch.data.magnitude;
			q_q   <= MAG_W'(1) << FRAC_BITS;
			h0_q  <= '0;
			h1_q  <= NUM_W'(1);
			k0_q  <= NUM_W'(1);
			k1_q  <= '0;
		end
		if (state_q == S_MULK) begin
			hfit_q <= mac_fits;
			h2_q   <= mac_value;
		end
		if (state_q == S_CHECK && hfit_q && mac_fits) begin
			h0_q <= h1_q;
			h1_q <= h2_q;
			k0_q <= k1_q;
			k1_q <= mac_value;
			p_q  <= q_q;
			q_q  <= div_rem;
		end
	end

	assign value_ch.ready               = (state_q == S_IDLE);
	assign ratio_ch.valid               = (state_q == S_OUT);
	assign ratio_ch.data.result_negative = neg_q;
	assign ratio_ch.data.numerator      = h1_q;
	assign ratio_ch.data.denominator    = k1_q;

	`CFR_ASSERT_NEXT(a_accept_starts_div, accept, div_start_q && state_q == S_DIV)
	`CFR_ASSERT_NOW(a_done_in_div, div_done, state_q == S_DIV)
	`CFR_ASSERT_NEXT(a_stall_holds, state_q == S_OUT && !ratio_ch.ready,
		state_q == S_OUT && $stable(h1_q) && $stable(k1_q) && $stable(neg_q))

endmodule
`default_nettype wire
